// File: design/shatan_pkg.sv
// Package with widths, pipeline constants and the CORDIC angle table for the smoothed Heaviside.
`default_nettype none

package shatan_pkg;

  localparam int ATAN_ITERATIONS = 16;
  localparam int ANGLE_ROM_LEN   = 24;
  localparam int CORDIC_STAGES   =
    (ATAN_ITERATIONS < ANGLE_ROM_LEN) ? ATAN_ITERATIONS : ANGLE_ROM_LEN;

  // One multiply stage, one magnitude stage, the CORDIC stages and the output stage.
  localparam int NUM_STAGES = CORDIC_STAGES + 3;

  localparam int DIST_W  = 24;
  localparam int STEEP_W = 16;
  localparam int PROD_W  = DIST_W + STEEP_W;
  localparam int XY_W    = PROD_W + 3;
  localparam int Z_W     = 34;
  localparam int H_W     = 36;
  localparam int LEVEL_W = 16;
  localparam int ANGLE_W = 32;

  localparam logic [STEEP_W-1:0] STEEPNESS_RESET = 16'd4915;
  localparam logic [63:0]        PI_Q60          = 64'h3243_F6A8_885A_308D;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Angle atan(2^-i)/pi in Q0.32, evaluated at elaboration only.
  function automatic logic [ANGLE_W-1:0] atan_angle(input int i);
    logic signed [63:0] sum;
    logic        [63:0] term;
    logic        [63:0] r;
    logic        [33:0] q;
    int                 pw;
    if (i == 0) begin
      return 32'h4000_0000;
    end
    sum = '0;
    for (int k = 0; k < 61; k++) begin
      pw = 60 - (2 * k + 1) * i;
      if (pw >= 0) begin
        term = udiv64(64'd1 << pw, 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    r = 64'(sum);
    q = '0;
    for (int b = 0; b < 33; b++) begin
      r = r << 1;
      q = {q[32:0], 1'b0};
      if (r >= PI_Q60) begin
        r    = r - PI_Q60;
        q[0] = 1'b1;
      end
    end
    q = q + 34'd1;
    return q[32:1];
  endfunction

endpackage

`default_nettype wire

// File: design/smoothed_heaviside_arctan.sv
// Top level: pipelined smoothed Heaviside level = 0.5 - atan(s*d)/pi with CORDIC vectoring.
//
//  Channel  Direction  Width  Contents
//  s_axis   in         24     distance, signed Q15.8
//  m_axis   out        16     level, unsigned Q0.16
//  cfg      in         16     steepness, unsigned Q4.12
//
// One word enters per cycle while the pipeline is not stalled. Each word passes through one
// multiply stage, one magnitude stage, one stage per CORDIC iteration and the output
// register. Each stage holds its word while the next one is full and stalled, and
// empty stages fill up, so a stall loses nothing. Reset clears the valid bits and loads
// the steepness reset value; configuration is always ready.
`default_nettype none

module smoothed_heaviside_arctan (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [23:0] distance
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] level
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i      // [15:0] steepness
);

  localparam int NS = shatan_pkg::NUM_STAGES;
  localparam int CS = shatan_pkg::CORDIC_STAGES;
  localparam int XW = shatan_pkg::XY_W;
  localparam int ZW = shatan_pkg::Z_W;
  localparam int PW = shatan_pkg::PROD_W;
  localparam int HW = shatan_pkg::H_W;

  logic [shatan_pkg::STEEP_W-1:0] steepness_q;
  logic [NS-1:0]                  valid_q;
  logic [NS-1:0]                  valid_in;
  logic [NS:0]                    ready_s;

  logic signed [PW-1:0] p_q;
  logic signed [XW-1:0] y0_q;
  logic                 neg0_q;

  logic signed [XW-1:0] x_q   [CS];
  logic signed [XW-1:0] y_q   [CS];
  logic signed [ZW-1:0] z_q   [CS];
  logic                 neg_q [CS];

  logic signed [HW-1:0]                 h_s;
  logic        [HW-1:0]                 lvl_s;
  logic        [shatan_pkg::LEVEL_W-1:0] level_d;
  logic        [shatan_pkg::LEVEL_W-1:0] level_q;
  logic        [PW-1:0]                 pmag_s;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steepness_q <= shatan_pkg::STEEPNESS_RESET;
    end else if (cfg_valid_i) begin
      steepness_q <= cfg_data_i;
    end
  end

  assign valid_in = {valid_q[NS-2:0], s_axis_tvalid};

  always_comb begin
    ready_s[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      ready_s[k] = !valid_q[k] || ready_s[k+1];
    end
  end

  assign s_axis_tready = ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ready_s[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (ready_s[0] && valid_in[0]) begin
      p_q <= PW'($signed(s_axis_tdata)) * PW'($signed({1'b0, steepness_q}));
    end
  end

  // Magnitude stage.
  assign pmag_s = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);

  always_ff @(posedge clk_i) begin
    if (ready_s[1] && valid_in[1]) begin
      y0_q   <= $signed({3'b000, pmag_s});
      neg0_q <= p_q[PW-1];
    end
  end

  // CORDIC vectoring, one iteration per stage.
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic [shatan_pkg::ANGLE_W-1:0] Angle = shatan_pkg::atan_angle(i);
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic                 neg_in;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign x_in   = XW'(64'sd1 <<< 20);
      assign y_in   = y0_q;
      assign z_in   = '0;
      assign neg_in = neg0_q;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign ang = $signed({2'b00, Angle});

    always_ff @(posedge clk_i) begin
      if (ready_s[i+2] && valid_in[i+2]) begin
        neg_q[i] <= neg_in;
        if (!y_in[XW-1]) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + ang;
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - ang;
        end
      end
    end
  end

  // Output stage: reflect, round to 16 bits and clamp.
  always_comb begin
    if (neg_q[CS-1]) begin
      h_s = $signed(HW'(64'sd1 <<< 31)) + HW'(z_q[CS-1]);
    end else begin
      h_s = $signed(HW'(64'sd1 <<< 31)) - HW'(z_q[CS-1]);
    end
    if (h_s[HW-1]) begin
      lvl_s = '0;
    end else begin
      lvl_s = (HW'(h_s) + HW'(32768)) >> 16;
    end
    if (lvl_s > HW'(65535)) begin
      level_d = '1;
    end else begin
      level_d = lvl_s[shatan_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s[NS-1] && valid_in[NS-1]) begin
      level_q <= level_d;
    end
  end

  assign m_axis_tvalid = valid_q[NS-1];
  assign m_axis_tdata  = level_q;

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("Input stalled although the output side is free.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("Accepted word did not enter the multiply stage.");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NS-2] && m_axis_tvalid && !m_axis_tready) |=> valid_q[NS-2])
    else $error("Word dropped ahead of a stalled output.");
`endif

endmodule

`default_nettype wire
